// File: rtl/core/tld_pkg.sv
// tld_pkg: shared types, character codes and label tables of the line decoder.
// No dependencies.
package tld_pkg;

    localparam int LABEL_COUNT = 22;
    localparam int CODE_W      = 5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_J     = 8'h4A;

    localparam logic [5:0] SUM_MASK   = 6'h3F;
    localparam logic [7:0] SUM_OFFSET = 8'h20;

    localparam logic [CODE_W-1:0] OPTARIF_CODE = 5'd1;

    localparam logic [2:0] TARIFF_NONE    = 3'd0;
    localparam logic [2:0] TARIFF_BASE    = 3'd1;
    localparam logic [2:0] TARIFF_OFFPEAK = 3'd2;
    localparam logic [2:0] TARIFF_PEAKDAY = 3'd3;
    localparam logic [2:0] TARIFF_TEMPO   = 3'd4;

    // labels packed first char high, zero padded on the left
    localparam logic [63:0] LABEL_NAMES [LABEL_COUNT] = '{
        "ADCO", "OPTARIF", "ISOUSC", "BASE", "HCHC", "HCHP", "EJPHPM", "EJPHN",
        "BBRHCJB", "BBRHPJB", "BBRHCJW", "BBRHPJW", "BBRHCJR", "BBRHPJR",
        "PTEC", "IINST", "IMAX", "PAPP", "DEMAIN", "HHPHC", "ADPS", "MOTDETAT"
    };

    // number of value characters taken for each label
    localparam logic [3:0] LABEL_WIDTHS [LABEL_COUNT] = '{
        4'd12, 4'd4, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
        4'd9, 4'd9, 4'd9, 4'd4, 4'd3, 4'd3, 4'd5, 4'd4, 4'd1, 4'd3, 4'd6
    };

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_match;

    typedef struct packed {
        logic [CODE_W-1:0] label_code;
        logic [39:0]       numeric_value;
        logic              is_number;
        logic [31:0]       value_head;
        logic [2:0]        tariff_option;
    } t_record;

endpackage

// File: rtl/core/tld_label_match.sv
// tld_label_match: compares the packed label against the fixed label table.
// Depends on tld_pkg.
module tld_label_match (
    input  logic [63:0]     i_label_chars,
    output tld_pkg::t_match o_match
);

    always_comb begin
        o_match = '0;
        // table names are distinct, so at most one entry hits
        for (int i = 0; i < tld_pkg::LABEL_COUNT; i++) begin
            if (i_label_chars == tld_pkg::LABEL_NAMES[i]) begin
                o_match.hit  = 1'b1;
                o_match.code = tld_pkg::CODE_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/tld_line_tracker.sv
// tld_line_tracker: per-line state (checksum, label, value digits) and record build.
// Depends on tld_pkg and tld_label_match.
module tld_line_tracker #(
    parameter int LINE_BYTES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_rec_valid,
    output tld_pkg::t_record o_rec
);

    localparam int POS_W = $clog2(LINE_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_BYTES - 1);

    logic [POS_W-1:0]           r_pos, n_pos;
    logic [5:0]                 r_lagged, n_lagged;
    logic [15:0]                r_recent, n_recent;
    logic [63:0]                r_label, n_label;
    logic                       r_space, n_space;
    logic [tld_pkg::CODE_W-1:0] r_matched, n_matched;
    logic                       r_lvalid, n_lvalid;
    logic [3:0]                 r_taken, n_taken;
    logic [39:0]                r_acc, n_acc;
    logic                       r_digits, n_digits;
    logic [31:0]                r_head, n_head;
    logic                       r_ovf, n_ovf;

    tld_pkg::t_match match;
    logic            is_digit;
    logic            sum_ok;

    tld_label_match u_match (
        .i_label_chars (r_label),
        .o_match       (match)
    );

    assign is_digit = (i_byte >= tld_pkg::CH_ZERO) && (i_byte <= tld_pkg::CH_NINE);
    assign sum_ok   = ({2'b00, r_lagged} + tld_pkg::SUM_OFFSET) == r_recent[7:0];

    // record fields come straight from the current line state
    always_comb begin
        o_rec.label_code    = r_matched;
        o_rec.is_number     = r_digits && (r_taken != 4'd0);
        o_rec.numeric_value = o_rec.is_number ? r_acc : 40'd0;
        o_rec.value_head    = r_head;
        o_rec.tariff_option = tld_pkg::TARIFF_NONE;
        if (r_matched == tld_pkg::OPTARIF_CODE) begin
            case (r_head[23:16])
                tld_pkg::CH_A: o_rec.tariff_option = tld_pkg::TARIFF_BASE;
                tld_pkg::CH_C: o_rec.tariff_option = tld_pkg::TARIFF_OFFPEAK;
                tld_pkg::CH_J: o_rec.tariff_option = tld_pkg::TARIFF_PEAKDAY;
                tld_pkg::CH_B: o_rec.tariff_option = tld_pkg::TARIFF_TEMPO;
                default:       o_rec.tariff_option = tld_pkg::TARIFF_NONE;
            endcase
        end
    end

    assign o_rec_valid = i_step && (i_byte == tld_pkg::CH_CR) && !r_ovf
                         && (r_pos != '0) && r_lvalid && sum_ok;

    always_comb begin
        n_pos     = r_pos;
        n_lagged  = r_lagged;
        n_recent  = r_recent;
        n_label   = r_label;
        n_space   = r_space;
        n_matched = r_matched;
        n_lvalid  = r_lvalid;
        n_taken   = r_taken;
        n_acc     = r_acc;
        n_digits  = r_digits;
        n_head    = r_head;
        n_ovf     = r_ovf;
        if (i_step) begin
            if ((i_byte == tld_pkg::CH_LF) || (i_byte == tld_pkg::CH_NUL)
                || (i_byte == tld_pkg::CH_CR)) begin
                n_pos     = '0;
                n_lagged  = '0;
                n_recent  = '0;
                n_label   = '0;
                n_space   = 1'b0;
                n_matched = '0;
                n_lvalid  = 1'b0;
                n_taken   = '0;
                n_acc     = '0;
                n_digits  = 1'b1;
                n_head    = '0;
                n_ovf     = 1'b0;
            end else if (r_ovf) begin
                n_ovf = 1'b1;
            end else if (r_pos == LAST_POS) begin
                n_ovf = 1'b1;
            end else begin
                // checksum covers bytes older than the last two
                if (r_pos >= POS_W'(2))
                    n_lagged = (r_lagged + r_recent[13:8]) & tld_pkg::SUM_MASK;
                n_recent = {r_recent[7:0], i_byte};
                n_pos    = r_pos + POS_W'(1);
                if (!r_space) begin
                    if (i_byte == tld_pkg::CH_SPACE) begin
                        n_space   = 1'b1;
                        n_matched = match.code;
                        n_lvalid  = match.hit;
                    end else if (r_label[63:56] != 8'd0) begin
                        n_label = '1;       // over-long label never matches
                    end else begin
                        n_label = {r_label[55:0], i_byte};
                    end
                end else if (r_lvalid && (r_taken < tld_pkg::LABEL_WIDTHS[r_matched])) begin
                    case (r_taken)
                        4'd0:    n_head = r_head | {i_byte, 24'd0};
                        4'd1:    n_head = r_head | {8'd0, i_byte, 16'd0};
                        4'd2:    n_head = r_head | {16'd0, i_byte, 8'd0};
                        4'd3:    n_head = r_head | {24'd0, i_byte};
                        default: n_head = r_head;
                    endcase
                    if (is_digit)
                        n_acc = (r_acc << 3) + (r_acc << 1) + {36'd0, i_byte[3:0]};
                    else
                        n_digits = 1'b0;
                    n_taken = r_taken + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_lagged  <= '0;
            r_recent  <= '0;
            r_label   <= '0;
            r_space   <= 1'b0;
            r_matched <= '0;
            r_lvalid  <= 1'b0;
            r_taken   <= '0;
            r_acc     <= '0;
            r_digits  <= 1'b1;
            r_head    <= '0;
            r_ovf     <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_lagged  <= n_lagged;
            r_recent  <= n_recent;
            r_label   <= n_label;
            r_space   <= n_space;
            r_matched <= n_matched;
            r_lvalid  <= n_lvalid;
            r_taken   <= n_taken;
            r_acc     <= n_acc;
            r_digits  <= n_digits;
            r_head    <= n_head;
            r_ovf     <= n_ovf;
        end
    end

endmodule

// File: rtl/core/teleinfo_line_decoder_unit.sv
// teleinfo_line_decoder_unit: top level of the historic-mode meter line decoder.
// Depends on tld_pkg and tld_line_tracker (which uses tld_label_match).
//
// Takes one received meter byte per transfer and emits one record for each
// line that closes with a carriage return, passes the six-bit checksum and
// carries a known label. Line feed or a zero byte restarts the line; lines
// longer than LINE_BYTES-1 bytes are dropped. A byte is captured in an input
// register, applied to the line state when the byte stage advances, and a
// resulting record lands in an output register. Rate: one byte per cycle
// sustained while the output register is not stalled; the closing carriage
// return passes the input register, and its record is held valid in the
// output register. The only limit is the output register, which stalls the
// byte stage only while a record waits and the consumer holds i_rec_ready low. No clearing pass after reset.
module teleinfo_line_decoder_unit #(
    parameter int LINE_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_rec_valid,
    input  logic        i_rec_ready,
    output logic [4:0]  o_label_code,
    output logic [39:0] o_numeric_value,
    output logic        o_is_number,
    output logic [31:0] o_value_head,
    output logic [2:0]  o_tariff_option
);

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // output stage
    logic             r_out_valid;
    tld_pkg::t_record r_out;

    logic             advance;   // input stage byte applied this cycle
    logic             rec_valid;
    tld_pkg::t_record rec;

    // byte stage moves whenever the output register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_rec_ready);
    assign o_rx_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    tld_line_tracker #(
        .LINE_BYTES (LINE_BYTES)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rec_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_rec_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_valid) begin
            r_out <= rec;
        end
    end

    assign o_rec_valid     = r_out_valid;
    assign o_label_code    = r_out.label_code;
    assign o_numeric_value = r_out.numeric_value;
    assign o_is_number     = r_out.is_number;
    assign o_value_head    = r_out.value_head;
    assign o_tariff_option = r_out.tariff_option;

`ifndef SYNTHESIS
    // a record built this cycle must be presented next cycle
    a_rec_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_valid |=> o_rec_valid)
        else $error("record not presented after build");

    // ready low only while a byte waits behind a stalled record
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (r_in_valid && r_out_valid && !i_rec_ready))
        else $error("input stalled without cause");

    // non-numeric values report zero
    a_num_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && !o_is_number) |-> (o_numeric_value == 40'd0))
        else $error("numeric value set on non-number");

    // tariff option only for the tariff label
    a_tariff_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_valid && (o_label_code != tld_pkg::OPTARIF_CODE))
        |-> (o_tariff_option == tld_pkg::TARIFF_NONE))
        else $error("tariff option on wrong label");
`endif

endmodule

// File: sim/tb_teleinfo_line_decoder_unit.sv
// tb_teleinfo_line_decoder_unit: self-checking bench for the meter line decoder.
// Depends on tld_pkg and teleinfo_line_decoder_unit; drives directed lines, then random
// framed lines, broken lines and raw noise, and checks records against a local decoder.
module tb_teleinfo_line_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES     = 32;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 1380;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;     // margin after the last owed record is taken
    localparam int REPORT_LIMIT   = 10;
    localparam int DIR_ROWS       = 25;

    // label codes used in the typed rows of the directed table
    localparam logic [tld_pkg::CODE_W-1:0] LBL_ADCO  = 5'd0;
    localparam logic [tld_pkg::CODE_W-1:0] LBL_BASE  = 5'd3;
    localparam logic [tld_pkg::CODE_W-1:0] LBL_HHPHC = 5'd19;

    localparam tld_pkg::t_record NO_REC = '0;

    // idle mixes: none, sender idles, receiver stalls, both
    localparam int IDLE_PCT  [4] = '{0, 48, 0, 15};
    localparam int STALL_PCT [4] = '{0, 0, 48, 15};

    typedef enum logic [1:0] {LEAD_NONE, LEAD_LF, LEAD_NUL} t_lead;
    typedef enum logic [1:0] {TAIL_SUM, TAIL_BADSUM, TAIL_CR, TAIL_OPEN} t_tail;
    // how the closing CR is checked: local decoder, typed record, or no record
    typedef enum logic [1:0] {EXP_MODEL, EXP_TYPED, EXP_NONE} t_exp;

    typedef struct packed {
        t_lead            lead;
        t_tail            tail;
        t_exp             kind;
        tld_pkg::t_record rec;
    } t_row;

    // ------------------------------------------------------------------
    // DUT and its drive
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_rec_valid;
    logic        i_rec_ready = 1'b0;
    logic [4:0]  o_label_code;
    logic [39:0] o_numeric_value;
    logic        o_is_number;
    logic [31:0] o_value_head;
    logic [2:0]  o_tariff_option;

    teleinfo_line_decoder_unit #(
        .LINE_BYTES(LINE_BYTES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_rec_valid    (o_rec_valid),
        .i_rec_ready    (i_rec_ready),
        .o_label_code   (o_label_code),
        .o_numeric_value(o_numeric_value),
        .o_is_number    (o_is_number),
        .o_value_head   (o_value_head),
        .o_tariff_option(o_tariff_option)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    tld_pkg::t_record expected_records [$];   // records owed by the DUT, oldest first
    logic [7:0]       line_q [$];             // line body being built before it is sent
    int               send_idle_pct = 0;
    int               rec_stall_pct = 0;
    int               bytes_sent = 0;
    int               lines_sent = 0;
    int               records_checked = 0;
    int               mismatch_count = 0;
    int               quiet_cycles = 0;

    // Local line decoder state, one copy of what the DUT tracks per line.
    logic [5:0]                 ln_len;      // line bytes held
    logic [5:0]                 ln_sum;      // six-bit sum of bytes older than the last two
    logic [15:0]                ln_last2;    // last two line bytes, newest low
    logic [63:0]                ln_label;    // label characters, newest low, all ones if long
    logic                       ln_space;
    logic [tld_pkg::CODE_W-1:0] ln_code;
    logic                       ln_known;
    logic [3:0]                 ln_taken;    // value characters consumed
    logic [39:0]                ln_value;
    logic                       ln_digits;
    logic [31:0]                ln_head;
    logic                       ln_dropped;  // line ran past LINE_BYTES-1

    // ------------------------------------------------------------------
    // Directed table: one row per line. Records are typed in only where
    // they are obvious; EXP_MODEL rows go through the local decoder.
    // ------------------------------------------------------------------
    string dir_text [DIR_ROWS] = '{
        "HHPHC A",                           // first line after reset, no LF
        "ADCO 012345678901",
        "OPTARIF BASE",
        "OPTARIF HC..",
        "OPTARIF EJP.",
        "OPTARIF BBR(",
        "OPTARIF ZZZZ",                      // unknown tariff letter
        "BASE 999999999",
        "ADCO 999999999999",                 // widest value
        "ISOUSC 45",
        "PTEC TH..",
        "HCHC 12",                           // short value runs into the checksum
        "PAPP 01230",                        // bad checksum
        "",                                  // empty line
        " ",                                 // lone space, empty label
        "BBRHCJBXX 000123456",               // label longer than eight chars
        "DEMAIN",                            // no space at all
        "ADCO 01234567890123456789012345",   // too long, dropped
        "MOTDETAT 00000012345678901234",     // exactly the longest line
        "IINST 0",                           // abandoned ...
        "PAPP 01230",                        // ... and restarted by a zero byte
        "EJPHN 00",                          // abandoned ...
        "HHPHC Y",                           // ... and restarted by a line feed
        "XYZ 1",                             // unknown label
        "EJPHPM 000004567"
    };

    t_row dir_rows [DIR_ROWS] = '{
        '{LEAD_NONE, TAIL_SUM, EXP_TYPED,
          {LBL_HHPHC, 40'd0, 1'b0, 32'h4100_0000, tld_pkg::TARIFF_NONE}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {LBL_ADCO, 40'd12345678901, 1'b1, "0123", tld_pkg::TARIFF_NONE}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {tld_pkg::OPTARIF_CODE, 40'd0, 1'b0, "BASE", tld_pkg::TARIFF_BASE}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {tld_pkg::OPTARIF_CODE, 40'd0, 1'b0, "HC..", tld_pkg::TARIFF_OFFPEAK}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {tld_pkg::OPTARIF_CODE, 40'd0, 1'b0, "EJP.", tld_pkg::TARIFF_PEAKDAY}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {tld_pkg::OPTARIF_CODE, 40'd0, 1'b0, "BBR(", tld_pkg::TARIFF_TEMPO}},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {LBL_BASE, 40'd999999999, 1'b1, "9999", tld_pkg::TARIFF_NONE}},
        '{LEAD_LF, TAIL_SUM, EXP_TYPED,
          {LBL_ADCO, 40'd999999999999, 1'b1, "9999", tld_pkg::TARIFF_NONE}},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_BADSUM, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_CR, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_CR, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_CR, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_OPEN, EXP_MODEL, NO_REC},
        '{LEAD_NUL, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_NONE, TAIL_OPEN, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_NONE, NO_REC},
        '{LEAD_LF, TAIL_SUM, EXP_MODEL, NO_REC}
    };

    // ------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------
    task automatic append_char(input logic [7:0] c);
        line_q = {line_q, c};
    endtask

    task automatic owe_record(input tld_pkg::t_record r);
        expected_records = {expected_records, r};
    endtask

    // ------------------------------------------------------------------
    // Local decoder
    // ------------------------------------------------------------------
    task automatic restart_line();
        ln_len     = '0;
        ln_sum     = '0;
        ln_last2   = '0;
        ln_label   = '0;
        ln_space   = 1'b0;
        ln_code    = '0;
        ln_known   = 1'b0;
        ln_taken   = '0;
        ln_value   = '0;
        ln_digits  = 1'b1;
        ln_head    = '0;
        ln_dropped = 1'b0;
    endtask

    // Applies one received byte; found is set when it closes a good line.
    task automatic decode_byte(input logic [7:0] c, output logic found,
                               output tld_pkg::t_record rec);
        found = 1'b0;
        rec   = NO_REC;
        if (c == tld_pkg::CH_LF || c == tld_pkg::CH_NUL) begin
            restart_line();
            return;
        end
        if (c == tld_pkg::CH_CR) begin
            if (!ln_dropped && ln_len != 0 && ln_known &&
                ({2'b00, ln_sum} + tld_pkg::SUM_OFFSET) == ln_last2[7:0]) begin
                found             = 1'b1;
                rec.label_code    = ln_code;
                rec.is_number     = ln_digits && ln_taken != 0;
                rec.numeric_value = rec.is_number ? ln_value : '0;
                rec.value_head    = ln_head;
                rec.tariff_option = tld_pkg::TARIFF_NONE;
                if (ln_code == tld_pkg::OPTARIF_CODE) begin
                    // tariff comes from the second value character
                    case (ln_head[23:16])
                        tld_pkg::CH_A: rec.tariff_option = tld_pkg::TARIFF_BASE;
                        tld_pkg::CH_C: rec.tariff_option = tld_pkg::TARIFF_OFFPEAK;
                        tld_pkg::CH_J: rec.tariff_option = tld_pkg::TARIFF_PEAKDAY;
                        tld_pkg::CH_B: rec.tariff_option = tld_pkg::TARIFF_TEMPO;
                        default:       rec.tariff_option = tld_pkg::TARIFF_NONE;
                    endcase
                end
            end
            restart_line();
            return;
        end
        if (ln_dropped)
            return;
        if (ln_len >= LINE_BYTES - 1) begin
            ln_dropped = 1'b1;
            return;
        end
        // the checksum covers everything but the last two line bytes
        if (ln_len >= 2)
            ln_sum = 6'(ln_sum + ln_last2[15:8]);
        ln_last2 = {ln_last2[7:0], c};
        ln_len   = ln_len + 1'b1;
        if (!ln_space) begin
            if (c == tld_pkg::CH_SPACE) begin
                ln_space = 1'b1;
                ln_known = 1'b0;
                ln_code  = '0;
                for (int k = 0; k < tld_pkg::LABEL_COUNT; k++) begin
                    if (!ln_known && ln_label == tld_pkg::LABEL_NAMES[k]) begin
                        ln_known = 1'b1;
                        ln_code  = k[tld_pkg::CODE_W-1:0];
                    end
                end
            end else if (ln_label[63:56] != 8'h00) begin
                ln_label = '1;
            end else begin
                ln_label = {ln_label[55:0], c};
            end
            return;
        end
        if (ln_known && ln_taken < tld_pkg::LABEL_WIDTHS[ln_code]) begin
            if (ln_taken < 4)
                ln_head[31 - 8 * ln_taken -: 8] = c;
            if (c >= tld_pkg::CH_ZERO && c <= tld_pkg::CH_NINE)
                ln_value = 40'(ln_value * 10 + 40'(c - tld_pkg::CH_ZERO));
            else
                ln_digits = 1'b0;
            ln_taken = ln_taken + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Byte sender: optional idle gap, then hold valid until the transfer.
    // Valid is left high afterwards so the next byte can follow at once.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input t_exp kind,
                             input tld_pkg::t_record typed);
        logic             found;
        tld_pkg::t_record rec;
        while ($urandom_range(99) < send_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready)
            @(posedge i_clk);
        bytes_sent++;
        decode_byte(b, found, rec);
        // typed rows override the local decoder on their closing CR
        if (b == tld_pkg::CH_CR && kind == EXP_TYPED)
            owe_record(typed);
        else if (found && !(b == tld_pkg::CH_CR && kind == EXP_NONE))
            owe_record(rec);
    endtask

    // Sends an optional restart byte, the body in line_q, then the tail.
    task automatic send_line(input t_lead lead, input t_tail tail, input t_exp kind,
                             input tld_pkg::t_record typed);
        logic [5:0] sum;
        sum = '0;
        if (lead == LEAD_LF)
            send_byte(tld_pkg::CH_LF, EXP_MODEL, NO_REC);
        else if (lead == LEAD_NUL)
            send_byte(tld_pkg::CH_NUL, EXP_MODEL, NO_REC);
        foreach (line_q[i]) begin
            sum = 6'(sum + line_q[i]);
            send_byte(line_q[i], EXP_MODEL, NO_REC);
        end
        case (tail)
            TAIL_SUM, TAIL_BADSUM: begin
                if (tail == TAIL_BADSUM)
                    sum = sum + 6'd1;
                send_byte(tld_pkg::CH_SPACE, EXP_MODEL, NO_REC);
                send_byte({2'b00, sum} + tld_pkg::SUM_OFFSET, EXP_MODEL, NO_REC);
                send_byte(tld_pkg::CH_CR, kind, typed);
            end
            TAIL_CR: send_byte(tld_pkg::CH_CR, kind, typed);
            default: ;
        endcase
        lines_sent++;
    endtask

    task automatic push_label(input int idx);
        for (int k = 7; k >= 0; k--) begin
            if (tld_pkg::LABEL_NAMES[idx][8 * k +: 8] != 8'h00)
                append_char(tld_pkg::LABEL_NAMES[idx][8 * k +: 8]);
        end
    endtask

    // mostly digits, otherwise any byte that is not a terminator
    task automatic push_value_char();
        logic [7:0] c;
        if ($urandom_range(99) < 85) begin
            c = 8'(tld_pkg::CH_ZERO + $urandom_range(9));
        end else begin
            do
                c = 8'($urandom_range(255, 1));
            while (c == tld_pkg::CH_LF || c == tld_pkg::CH_CR);
        end
        append_char(c);
    endtask

    // ------------------------------------------------------------------
    // Record checker: ready toggles at random, each transfer is compared
    // field by field with the oldest pending record.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        tld_pkg::t_record want;
        i_rec_ready <= ($urandom_range(99) >= rec_stall_pct);
        if (i_rst_n && o_rec_valid && i_rec_ready) begin
            records_checked++;
            if (expected_records.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("ERROR: record with none pending: code %0d value %0d head %h",
                             o_label_code, o_numeric_value, o_value_head);
            end else begin
                want = expected_records.pop_front();
                if (o_label_code !== want.label_code ||
                    o_numeric_value !== want.numeric_value ||
                    o_is_number !== want.is_number ||
                    o_value_head !== want.value_head ||
                    o_tariff_option !== want.tariff_option) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"ERROR: record %0d: code %0d/%0d value %0d/%0d ",
                                  "num %0d/%0d head %h/%h tariff %0d/%0d (exp/got)"},
                                 records_checked,
                                 want.label_code, o_label_code,
                                 want.numeric_value, o_numeric_value,
                                 want.is_number, o_is_number,
                                 want.value_head, o_value_head,
                                 want.tariff_option, o_tariff_option);
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_rec_valid && i_rec_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles, %0d records pending",
                     quiet_cycles, expected_records.size());
            $display("teleinfo_line_decoder_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int    roll;
        int    idx;
        int    nval;
        int    phase;
        int    dir_bytes;
        t_lead lead;
        t_tail tail;

        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        restart_line();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines, no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            line_q.delete();
            for (int i = 0; i < dir_text[r].len(); i++)
                append_char(dir_text[r][i]);
            send_line(dir_rows[r].lead, dir_rows[r].tail, dir_rows[r].kind, dir_rows[r].rec);
        end
        dir_bytes = bytes_sent;

        // random part: mostly framed lines with random content, the rest broken
        // lines and raw noise; the idle mix steps through four phases
        while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
            phase = (bytes_sent - dir_bytes) * 4 / RANDOM_BYTES;
            if (phase > 3)
                phase = 3;
            send_idle_pct = IDLE_PCT[phase];
            rec_stall_pct = STALL_PCT[phase];

            line_q.delete();
            roll = $urandom_range(99);
            idx  = $urandom_range(tld_pkg::LABEL_COUNT - 1);
            case ($urandom_range(19))
                0:       lead = LEAD_NONE;
                1:       lead = LEAD_NUL;
                default: lead = LEAD_LF;
            endcase
            if (roll < 90) begin
                push_label(idx);
                // one label letter swapped for a random capital
                if (roll >= 78 && roll < 84)
                    line_q[$urandom_range(line_q.size() - 1)] =
                        8'($urandom_range(8'h5A, tld_pkg::CH_A));
                append_char(tld_pkg::CH_SPACE);
                if (roll >= 84)
                    nval = $urandom_range(40, 20);      // may run past the line limit
                else if ($urandom_range(9) < 6)
                    nval = tld_pkg::LABEL_WIDTHS[idx];
                else
                    nval = $urandom_range(14);
                repeat (nval) push_value_char();
                tail = (roll >= 70 && roll < 78) ? TAIL_BADSUM : TAIL_SUM;
                send_line(lead, tail, EXP_MODEL, NO_REC);
            end else begin
                repeat ($urandom_range(12, 1)) append_char(8'($urandom_range(255)));
                send_line(LEAD_NONE, TAIL_OPEN, EXP_MODEL, NO_REC);
            end
        end

        i_rx_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d lines (directed table, framed, broken and noise lines)",
                 bytes_sent, lines_sent);
        $display("under four idle/stall mixes; %0d records checked, %0d mismatches",
                 records_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("teleinfo_line_decoder_unit test passed");
        end else begin
            $display("teleinfo_line_decoder_unit test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tld_pkg.sv
rtl/core/tld_label_match.sv
rtl/core/tld_line_tracker.sv
rtl/core/teleinfo_line_decoder_unit.sv
sim/tb_teleinfo_line_decoder_unit.sv
